FILE: rtl/bpdc_pkg.sv
// ----------------------------------------------------------------------------
// bpdc_pkg
// Shared widths, limits, register codes and types for the buck PI controller.
// ----------------------------------------------------------------------------
package bpdc_pkg;

  localparam int PWM_MAX  = 255;
  localparam int SAMPLE_W = 10;
  localparam int DROP_W   = 10;
  localparam int DUTY_W   = 8;
  localparam int INTEG_W  = 16;
  // working width for the integrator sum before clamping
  localparam int SUM_W    = 18;
  // integrator holds duty scaled by 16
  localparam int FRAC_SH  = 4;
  localparam int FRAC_ONE = 1 << FRAC_SH;

  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic signed [SUM_W-1:0] INTEG_HI   = SUM_W'(3 * PWM_MAX * FRAC_ONE);
  localparam logic signed [SUM_W-1:0] INTEG_LO   = SUM_W'(-(PWM_MAX * FRAC_ONE));
  localparam logic signed [SUM_W-1:0] PWM_MAX_S  = SUM_W'(PWM_MAX);
  localparam logic signed [SUM_W-1:0] ROUND_ADJ  = SUM_W'(FRAC_ONE - 1);
  // largest reload: (PWM_MAX + max stage/2) * 16
  localparam logic signed [SUM_W-1:0] RELOAD_MAX =
    SUM_W'((PWM_MAX + (1 << (SAMPLE_W - 1)) - 1) * FRAC_ONE);

  // register index, taken from paddr[2]
  localparam logic REG_DROP_OFFSET = 1'b0;
  localparam logic REG_FULL_ON     = 1'b1;

  typedef struct packed {
    logic [DUTY_W-1:0]         duty;
    logic signed [INTEG_W-1:0] integ;
  } bpdc_result_t;

endpackage

FILE: rtl/bpdc_calc.sv
// ----------------------------------------------------------------------------
// bpdc_calc
// One PI step: integrate, clamp, form duty, back-calculate on saturation; full-on forces max duty.
// ----------------------------------------------------------------------------
module bpdc_calc import bpdc_pkg::*; (
  input  logic signed [INTEG_W-1:0] integ,
  input  logic [SAMPLE_W-1:0]       out_sample,
  input  logic [SAMPLE_W-1:0]       stage_sample,
  input  logic [DROP_W-1:0]         drop_offset,
  input  logic                      full_on_mode,
  output bpdc_result_t              result
);

  logic signed [SUM_W-1:0] err;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] clamp;
  logic signed [SUM_W-1:0] quot;
  logic signed [SUM_W-1:0] prop;
  logic signed [SUM_W-1:0] raw;
  logic signed [SUM_W-1:0] reload;

  always_comb begin
    err = $signed({{(SUM_W-SAMPLE_W){1'b0}}, out_sample})
        + $signed({{(SUM_W-DROP_W){1'b0}}, drop_offset})
        - $signed({{(SUM_W-SAMPLE_W){1'b0}}, stage_sample});
    sum = $signed({{(SUM_W-INTEG_W){integ[INTEG_W-1]}}, integ}) + (err <<< 1);

    if (sum > INTEG_HI) begin
      clamp = INTEG_HI;
    end else if (sum < INTEG_LO) begin
      clamp = INTEG_LO;
    end else begin
      clamp = sum;
    end

    // divide by 16, truncating toward zero
    if (clamp[SUM_W-1]) begin
      quot = (clamp + ROUND_ADJ) >>> FRAC_SH;
    end else begin
      quot = clamp >>> FRAC_SH;
    end

    prop = $signed({{(SUM_W-SAMPLE_W+1){1'b0}}, stage_sample[SAMPLE_W-1:1]});
    raw  = quot - prop;

    if (raw > PWM_MAX_S) begin
      reload       = (PWM_MAX_S + prop) <<< FRAC_SH;
      result.duty  = DUTY_W'(PWM_MAX);
      result.integ = reload[INTEG_W-1:0];
    end else if (raw[SUM_W-1]) begin
      reload       = prop <<< FRAC_SH;
      result.duty  = '0;
      result.integ = reload[INTEG_W-1:0];
    end else begin
      reload       = clamp;
      result.duty  = raw[DUTY_W-1:0];
      result.integ = clamp[INTEG_W-1:0];
    end

    if (full_on_mode) begin
      result.duty = DUTY_W'(PWM_MAX);
    end
  end

endmodule

FILE: rtl/buck_pi_duty_controller.sv
// ----------------------------------------------------------------------------
// buck_pi_duty_controller
// PI duty controller for a buck stage with back-calculation anti-windup.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  in      | in        | in_valid / in_stall  | out_sample, stage_sample
//  out     | out       | out_valid / out_stall| duty
//  cfg     | in        | APB psel/penable     | drop_offset, full_on_mode
//
//  One word per cycle sustained while out_stall is low; a word passes through
//  the input register and the result register, with the integrator updated between them.
//  Synchronous reset clears valids, integrator and both config registers; data registers are not reset.
//  A stalled result holds a full input register; in_stall rises only then.
// ----------------------------------------------------------------------------
module buck_pi_duty_controller import bpdc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] out_sample,
  input  logic [SAMPLE_W-1:0] stage_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DUTY_W-1:0]   duty,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  logic [DROP_W-1:0]         drop_offset;
  logic                      full_on_mode;
  logic signed [INTEG_W-1:0] integ;
  logic                      s1_valid;
  logic [SAMPLE_W-1:0]       s1_out_sample;
  logic [SAMPLE_W-1:0]       s1_stage_sample;
  logic                      advance;
  logic                      s1_fire;
  logic                      cfg_write;
  bpdc_result_t              calc;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_offset  <= '0;
      full_on_mode <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_DROP_OFFSET: drop_offset  <= pwdata[DROP_W-1:0];
        REG_FULL_ON:     full_on_mode <= pwdata[0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DROP_OFFSET: prdata = {{(APB_DW-DROP_W){1'b0}}, drop_offset};
      REG_FULL_ON:     prdata = {{(APB_DW-1){1'b0}}, full_on_mode};
      default:         prdata = '0;
    endcase
  end

  // result register drains or is empty
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign s1_fire  = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_out_sample   <= out_sample;
      s1_stage_sample <= stage_sample;
    end
  end

  bpdc_calc u_calc (
    .integ        (integ),
    .out_sample   (s1_out_sample),
    .stage_sample (s1_stage_sample),
    .drop_offset  (drop_offset),
    .full_on_mode (full_on_mode),
    .result       (calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      integ     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (s1_fire) begin
        integ <= calc.integ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      duty <= calc.duty;
    end
  end

`ifndef SYNTHESIS
  a_integ_range: assert property (@(posedge clk) disable iff (rst)
    ($signed({{(SUM_W-INTEG_W){integ[INTEG_W-1]}}, integ}) >= INTEG_LO) &&
    ($signed({{(SUM_W-INTEG_W){integ[INTEG_W-1]}}, integ}) <= RELOAD_MAX))
    else $error("integrator outside its clamp and reload range");

  a_integ_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_fire |=> $stable(integ))
    else $error("integrator changed without a word moving on");

  a_fire_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("word left input register but no result shown");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while pipeline could move");
`endif

endmodule
